@@ hdl/mrrs_pkg.sv @@
// Shared codes for the multilevel round-robin scheduler.
// Operation, status and slot-state codes; no dependencies.
`timescale 1ns / 1ps
package mrrs_pkg;

   typedef logic [1:0] op_type;
   typedef logic [1:0] status_type;
   typedef logic [1:0] slot_state_type;

   localparam op_type OP_TICK  = 2'd0;
   localparam op_type OP_RUN   = 2'd1;
   localparam op_type OP_SLEEP = 2'd2;
   localparam op_type OP_ALLOC = 2'd3;

   localparam status_type STAT_OK     = 2'd0;
   localparam status_type STAT_NOSLOT = 2'd1;
   localparam status_type STAT_FULL   = 2'd2;
   localparam status_type STAT_NORUN  = 2'd3;

   localparam slot_state_type SLOT_FREE   = 2'd0;
   localparam slot_state_type SLOT_ALLOC  = 2'd1;
   localparam slot_state_type SLOT_ACTIVE = 2'd2;

   // Slice values written by the clearing pass
   localparam logic [7:0] BOOT_SLICE_0 = 8'd2;
   localparam logic [7:0] BOOT_SLICE_1 = 8'd1;

endpackage

@@ hdl/mrrs_ram.sv @@
// Generic RAM: one write port, one read port, read data registered.
// No dependencies.
`timescale 1ns / 1ps
module mrrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write one entry, register the read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/multilevel_round_robin_scheduler_unit.sv @@
// Run and sleep may search the old level's list and shift it to close the gap;
// allocate scans the slot memory for the first free slot.
// One item at a time: busy stays high from start until the result beat.
// After reset a clearing pass loads the slot memory and the two boot list entries;
// busy is high throughout. The receiver cannot stall.
`timescale 1ns / 1ps
module multilevel_round_robin_scheduler_unit #(
   parameter int TASK_SLOTS = 64,
   parameter int LEVELS     = 8,
   parameter int PER_LEVEL  = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_operation,
   input  logic [5:0] req_task_id,
   input  logic signed [3:0] req_target_level,
   input  logic [7:0] req_slice_ticks,
   output logic       rsp_valid,
   output logic [1:0] rsp_status,
   output logic [5:0] rsp_result_task,
   output logic [7:0] rsp_reload_ticks,
   output logic       rsp_do_jump,
   output logic [3:0] rsp_active_level
);

   localparam int SW  = $clog2(TASK_SLOTS);
   localparam int LW  = $clog2(LEVELS);
   localparam int CW  = $clog2(PER_LEVEL + 1);
   localparam int PW  = (PER_LEVEL > 1) ? $clog2(PER_LEVEL) : 1;
   localparam int LA  = (LEVELS * PER_LEVEL > 1) ? $clog2(LEVELS * PER_LEVEL) : 1;
   localparam int SLW = 10 + LW;

   localparam logic [4:0] S_CLR   = 5'd0;
   localparam logic [4:0] S_IDLE  = 5'd1;
   localparam logic [4:0] S_AL_A  = 5'd2;
   localparam logic [4:0] S_AL_D  = 5'd3;
   localparam logic [4:0] S_SL_A  = 5'd4;
   localparam logic [4:0] S_SL_D  = 5'd5;
   localparam logic [4:0] S_B_A   = 5'd6;
   localparam logic [4:0] S_B_D   = 5'd7;
   localparam logic [4:0] S_TK    = 5'd8;
   localparam logic [4:0] S_RM_A  = 5'd9;
   localparam logic [4:0] S_RM_D  = 5'd10;
   localparam logic [4:0] S_SH_A  = 5'd11;
   localparam logic [4:0] S_SH_D  = 5'd12;
   localparam logic [4:0] S_ADD   = 5'd13;
   localparam logic [4:0] S_SLEND = 5'd14;
   localparam logic [4:0] S_WR    = 5'd15;
   localparam logic [4:0] S_FIN_A = 5'd16;
   localparam logic [4:0] S_FIN_D = 5'd17;
   localparam logic [4:0] S_SC_A  = 5'd18;
   localparam logic [4:0] S_SC_D  = 5'd19;
   localparam logic [4:0] S_OUT   = 5'd20;

   function automatic logic [LA-1:0] list_addr(input logic [LW-1:0] lvl,
                                                input logic [CW-1:0] idx);
      list_addr = LA'(LA'(lvl) * LA'(PER_LEVEL)) + LA'(idx);
   endfunction

   // registers
   logic [4:0]    state_ff, state_in;
   logic [SW-1:0] clr_ff, clr_in;
   logic [1:0]    op_ff, op_in;
   logic [SW-1:0] tid_ff, tid_in;
   logic [3:0]    tl_ff, tl_in;
   logic [7:0]    slice_ff, slice_in;
   logic [CW-1:0] cnt_ff [LEVELS];
   logic [CW-1:0] cnt_in [LEVELS];
   logic [PW-1:0] pos_ff [LEVELS];
   logic [PW-1:0] pos_in [LEVELS];
   logic [LW:0]   serv_ff, serv_in;
   logic          pend_ff, pend_in;
   logic [1:0]    t_st_ff, t_st_in;
   logic [LW-1:0] t_lvl_ff, t_lvl_in;
   logic [7:0]    t_slc_ff, t_slc_in;
   logic [LW-1:0] new_lvl_ff, new_lvl_in;
   logic [SW-1:0] k_ff, k_in;
   logic [CW-1:0] j_ff, j_in;
   logic [SW-1:0] before_ff, before_in;
   logic          before_v_ff, before_v_in;
   logic [SW-1:0] cur_ff, cur_in;
   logic          hit_ff, hit_in;
   logic [1:0]    status_ff, status_in;
   logic [7:0]    reload_ff, reload_in;
   logic          jump_ff, jump_in;

   // memory ports
   logic           slot_we;
   logic [SW-1:0]  slot_waddr, slot_raddr;
   logic [SLW-1:0] slot_wdata, slot_rdata;
   logic           list_we;
   logic [LA-1:0]  list_waddr, list_raddr;
   logic [SW-1:0]  list_wdata, list_rdata;

   mrrs_ram #(.WIDTH(SLW), .DEPTH(TASK_SLOTS)) u_slot_ram (
      .clock(clock), .wr_en(slot_we), .wr_addr(slot_waddr), .wr_data(slot_wdata),
      .rd_addr(slot_raddr), .rd_data(slot_rdata)
   );

   mrrs_ram #(.WIDTH(SW), .DEPTH(LEVELS * PER_LEVEL)) u_list_ram (
      .clock(clock), .wr_en(list_we), .wr_addr(list_waddr), .wr_data(list_wdata),
      .rd_addr(list_raddr), .rd_data(list_rdata)
   );

   logic [1:0]    rd_st;
   logic [LW-1:0] rd_lvl;
   logic [7:0]    rd_slc;
   assign rd_st  = slot_rdata[SLW-1 -: 2];
   assign rd_lvl = slot_rdata[8 +: LW];
   assign rd_slc = slot_rdata[7:0];

   // current task presence and list address
   logic          cur_v;
   logic [LW-1:0] serv_idx;
   logic [LA-1:0] cur_addr;
   assign serv_idx = serv_ff[LW-1:0];
   assign cur_v    = (32'(serv_ff) < 32'(LEVELS)) && (cnt_ff[serv_idx] != '0);
   assign cur_addr = list_addr(serv_idx, CW'(pos_ff[serv_idx]));

   // lowest occupied level, LEVELS when none
   logic [LW:0] resc_lvl;
   always_comb begin
      resc_lvl = (LW+1)'(LEVELS);
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (cnt_ff[i] != '0) resc_lvl = (LW+1)'(i);
      end
   end

   // level chosen by run
   logic [LW-1:0] run_lvl;
   always_comb begin
      if (tl_ff[3]) run_lvl = rd_lvl;
      else if (32'(tl_ff) >= 32'(LEVELS)) run_lvl = LW'(LEVELS - 1);
      else run_lvl = LW'(tl_ff);
   end

   logic [CW-1:0] rm_n;
   logic [PW-1:0] rm_p;
   assign rm_n = cnt_ff[t_lvl_ff];

   // sequencer
   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      op_in       = op_ff;
      tid_in      = tid_ff;
      tl_in       = tl_ff;
      slice_in    = slice_ff;
      cnt_in      = cnt_ff;
      pos_in      = pos_ff;
      serv_in     = serv_ff;
      pend_in     = pend_ff;
      t_st_in     = t_st_ff;
      t_lvl_in    = t_lvl_ff;
      t_slc_in    = t_slc_ff;
      new_lvl_in  = new_lvl_ff;
      k_in        = k_ff;
      j_in        = j_ff;
      before_in   = before_ff;
      before_v_in = before_v_ff;
      cur_in      = cur_ff;
      hit_in      = hit_ff;
      status_in   = status_ff;
      reload_in   = reload_ff;
      jump_in     = jump_ff;
      rm_p        = pos_ff[t_lvl_ff];
      slot_we     = 1'b0;
      slot_waddr  = tid_ff;
      slot_wdata  = {t_st_ff, t_lvl_ff, t_slc_ff};
      slot_raddr  = tid_ff;
      list_we     = 1'b0;
      list_waddr  = list_addr(t_lvl_ff, j_ff);
      list_wdata  = list_rdata;
      list_raddr  = cur_addr;

      unique case (state_ff)
         S_CLR: begin
            // clear every slot, load the two boot slots and their boot list entries
            slot_we    = 1'b1;
            slot_waddr = clr_ff;
            slot_wdata = '0;
            if (clr_ff == SW'(0)) begin
               slot_wdata = {mrrs_pkg::SLOT_ACTIVE, LW'(0), mrrs_pkg::BOOT_SLICE_0};
               list_we    = 1'b1;
               list_waddr = list_addr(LW'(0), CW'(0));
               list_wdata = SW'(0);
            end else if (clr_ff == SW'(1)) begin
               slot_wdata = {mrrs_pkg::SLOT_ACTIVE, LW'(LEVELS - 1),
                             mrrs_pkg::BOOT_SLICE_1};
               list_we    = 1'b1;
               list_waddr = list_addr(LW'(LEVELS - 1), CW'(0));
               list_wdata = SW'(1);
            end
            if (clr_ff == SW'(TASK_SLOTS - 1)) state_in = S_IDLE;
            else clr_in = clr_ff + SW'(1);
         end
         S_IDLE: begin
            if (start) begin
               op_in       = req_operation;
               tid_in      = SW'(req_task_id);
               tl_in       = req_target_level;
               slice_in    = req_slice_ticks;
               status_in   = mrrs_pkg::STAT_OK;
               reload_in   = '0;
               jump_in     = 1'b0;
               hit_in      = 1'b0;
               before_v_in = 1'b0;
               k_in        = '0;
               unique case (req_operation)
                  mrrs_pkg::OP_ALLOC: state_in = S_AL_A;
                  mrrs_pkg::OP_TICK:  state_in = S_B_A;
                  default: begin
                     if (32'(req_task_id) < 32'(TASK_SLOTS)) state_in = S_SL_A;
                     else state_in = S_FIN_A;
                  end
               endcase
            end
         end
         S_AL_A: begin
            slot_raddr = k_ff;
            state_in   = S_AL_D;
         end
         S_AL_D: begin
            // claim the first free slot or give up at the last one
            if (rd_st == mrrs_pkg::SLOT_FREE) begin
               t_st_in  = mrrs_pkg::SLOT_ALLOC;
               t_lvl_in = rd_lvl;
               t_slc_in = rd_slc;
               tid_in   = k_ff;
               state_in = S_WR;
            end else if (k_ff == SW'(TASK_SLOTS - 1)) begin
               status_in = mrrs_pkg::STAT_NOSLOT;
               cur_in    = '0;
               state_in  = S_OUT;
            end else begin
               k_in     = k_ff + SW'(1);
               state_in = S_AL_A;
            end
         end
         S_SL_A: begin
            slot_raddr = tid_ff;
            state_in   = S_SL_D;
         end
         S_SL_D: begin
            t_st_in  = rd_st;
            t_lvl_in = rd_lvl;
            t_slc_in = rd_slc;
            j_in     = '0;
            if (op_ff == mrrs_pkg::OP_RUN) begin
               new_lvl_in = run_lvl;
               if (slice_ff != '0) t_slc_in = slice_ff;
               pend_in = 1'b1;
               if (rd_st == mrrs_pkg::SLOT_ACTIVE && rd_lvl != run_lvl) state_in = S_RM_A;
               else if (rd_st != mrrs_pkg::SLOT_ACTIVE) state_in = S_ADD;
               else state_in = S_WR;
            end else begin
               if (rd_st == mrrs_pkg::SLOT_ACTIVE) state_in = S_B_A;
               else state_in = S_FIN_A;
            end
         end
         S_B_A: begin
            list_raddr = cur_addr;
            state_in   = S_B_D;
         end
         S_B_D: begin
            before_in   = list_rdata;
            before_v_in = cur_v;
            j_in        = '0;
            if (op_ff == mrrs_pkg::OP_TICK) state_in = S_TK;
            else state_in = S_RM_A;
         end
         S_TK: begin
            // advance round-robin in the served level; rescan if pending or empty
            if (32'(serv_ff) < 32'(LEVELS)) begin
               if (cnt_ff[serv_idx] == '0) begin
                  pos_in[serv_idx] = '0;
               end else if (32'(pos_ff[serv_idx]) + 32'd1 >= 32'(cnt_ff[serv_idx])) begin
                  pos_in[serv_idx] = '0;
               end else begin
                  pos_in[serv_idx] = pos_ff[serv_idx] + PW'(1);
               end
            end
            if (pend_ff || !cur_v) begin
               serv_in = resc_lvl;
               pend_in = 1'b0;
            end
            state_in = S_FIN_A;
         end
         S_RM_A: begin
            // search the old level's list for the task
            t_st_in    = mrrs_pkg::SLOT_ALLOC;
            list_raddr = list_addr(t_lvl_ff, j_ff);
            if (j_ff >= rm_n) begin
               state_in = (op_ff == mrrs_pkg::OP_RUN) ? S_ADD : S_SLEND;
            end else begin
               state_in = S_RM_D;
            end
         end
         S_RM_D: begin
            if (list_rdata == tid_ff) begin
               cnt_in[t_lvl_ff] = rm_n - CW'(1);
               if (32'(j_ff) < 32'(rm_p)) rm_p = rm_p - PW'(1);
               if (32'(rm_p) >= 32'(rm_n) - 32'd1) rm_p = '0;
               pos_in[t_lvl_ff] = rm_p;
               state_in = S_SH_A;
            end else begin
               j_in     = j_ff + CW'(1);
               state_in = S_RM_A;
            end
         end
         S_SH_A: begin
            // close the gap one entry at a time
            list_raddr = list_addr(t_lvl_ff, j_ff + CW'(1));
            if (j_ff < rm_n) state_in = S_SH_D;
            else state_in = (op_ff == mrrs_pkg::OP_RUN) ? S_ADD : S_SLEND;
         end
         S_SH_D: begin
            list_we    = 1'b1;
            list_waddr = list_addr(t_lvl_ff, j_ff);
            list_wdata = list_rdata;
            j_in       = j_ff + CW'(1);
            state_in   = S_SH_A;
         end
         S_ADD: begin
            // append to the new level's list if it has room
            t_lvl_in = new_lvl_ff;
            if (32'(cnt_ff[new_lvl_ff]) >= 32'(PER_LEVEL)) begin
               status_in = mrrs_pkg::STAT_FULL;
            end else begin
               list_we    = 1'b1;
               list_waddr = list_addr(new_lvl_ff, cnt_ff[new_lvl_ff]);
               list_wdata = tid_ff;
               cnt_in[new_lvl_ff] = cnt_ff[new_lvl_ff] + CW'(1);
               t_st_in    = mrrs_pkg::SLOT_ACTIVE;
            end
            state_in = S_WR;
         end
         S_SLEND: begin
            if (before_v_ff && before_ff == tid_ff) begin
               hit_in  = 1'b1;
               serv_in = resc_lvl;
               pend_in = 1'b0;
            end
            state_in = S_WR;
         end
         S_WR: begin
            slot_we    = 1'b1;
            slot_waddr = tid_ff;
            if (op_ff == mrrs_pkg::OP_ALLOC) begin
               cur_in   = tid_ff;
               state_in = S_OUT;
            end else begin
               state_in = S_FIN_A;
            end
         end
         S_FIN_A: begin
            list_raddr = cur_addr;
            state_in   = S_FIN_D;
         end
         S_FIN_D: begin
            cur_in   = cur_v ? list_rdata : '0;
            state_in = S_OUT;
            if (op_ff == mrrs_pkg::OP_TICK) begin
               if (cur_v) begin
                  jump_in  = !before_v_ff || (before_ff != list_rdata);
                  state_in = S_SC_A;
               end else begin
                  status_in = mrrs_pkg::STAT_NORUN;
               end
            end else if (hit_ff) begin
               if (cur_v) jump_in = 1'b1;
               else status_in = mrrs_pkg::STAT_NORUN;
            end
         end
         S_SC_A: begin
            slot_raddr = cur_ff;
            state_in   = S_SC_D;
         end
         S_SC_D: begin
            reload_in = rd_slc;
            state_in  = S_OUT;
         end
         S_OUT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold control under reset, advance otherwise
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff   <= '0;
         serv_ff  <= '0;
         pend_ff  <= 1'b0;
         for (int i = 0; i < LEVELS; i++) begin
            cnt_ff[i] <= (i == 0 || i == LEVELS - 1) ? CW'(1) : '0;
            pos_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         serv_ff  <= serv_in;
         pend_ff  <= pend_in;
         cnt_ff   <= cnt_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      tid_ff      <= tid_in;
      tl_ff       <= tl_in;
      slice_ff    <= slice_in;
      t_st_ff     <= t_st_in;
      t_lvl_ff    <= t_lvl_in;
      t_slc_ff    <= t_slc_in;
      new_lvl_ff  <= new_lvl_in;
      k_ff        <= k_in;
      j_ff        <= j_in;
      before_ff   <= before_in;
      before_v_ff <= before_v_in;
      cur_ff      <= cur_in;
      hit_ff      <= hit_in;
      status_ff   <= status_in;
      reload_ff   <= reload_in;
      jump_ff     <= jump_in;
   end

   // result beat
   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = (state_ff == S_OUT);
   assign rsp_status       = status_ff;
   assign rsp_result_task  = 6'(cur_ff);
   assign rsp_reload_ticks = reload_ff;
   assign rsp_do_jump      = jump_ff;
   assign rsp_active_level = 4'(serv_ff);

endmodule

@@ hdl/mrrs_checker.sv @@
// Port-level checks for the scheduler, bound to the top level.
// Depends on mrrs_pkg and multilevel_round_robin_scheduler_unit.
`timescale 1ns / 1ps
module mrrs_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [1:0] req_operation,
   input logic [5:0] req_task_id,
   input logic signed [3:0] req_target_level,
   input logic [7:0] req_slice_ticks,
   input logic       rsp_valid,
   input logic [1:0] rsp_status,
   input logic [5:0] rsp_result_task,
   input logic [7:0] rsp_reload_ticks,
   input logic       rsp_do_jump,
   input logic [3:0] rsp_active_level
);

   // one beat per item, then back to idle
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result beat longer than one cycle");

   // accepted item keeps the block busy
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy && !rsp_valid)
      else $error("accepted item not held busy");

   // failed allocate gives slot zero
   a_noslot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == mrrs_pkg::STAT_NOSLOT) |-> rsp_result_task == 6'd0)
      else $error("failed allocate returned a slot");

   // no runnable task means no jump, no reload and task zero
   a_norun_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == mrrs_pkg::STAT_NORUN)
         |-> (!rsp_do_jump && rsp_reload_ticks == 8'd0 && rsp_result_task == 6'd0))
      else $error("no runnable task but jump or reload given");

endmodule

bind multilevel_round_robin_scheduler_unit mrrs_checker u_mrrs_checker (.*);

@@ dv/multilevel_round_robin_scheduler_unit_test.sv @@
// Self-checking bench for the multilevel round-robin scheduler unit.
// Predicts every response beat with a built-in scheduler model; depends on mrrs_pkg and the unit.
`timescale 1ns / 1ps
module multilevel_round_robin_scheduler_unit_test;

   localparam int SLOTS = 64;
   localparam int NLEV  = 8;
   localparam int DEPTH = 16;
   localparam int CYCLE_LIMIT = 1500000;

   typedef struct packed {
      mrrs_pkg::op_type  op;
      logic [5:0]        tid;
      logic signed [3:0] lvl;
      logic [7:0]        slice;
   } cmd_t;

   typedef struct packed {
      mrrs_pkg::status_type status;
      logic [5:0]  task_id;
      logic [7:0]  reload;
      logic        jump;
      logic [3:0]  level;
   } resp_t;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [1:0] req_operation = '0;
   logic [5:0] req_task_id = '0;
   logic signed [3:0] req_target_level = '0;
   logic [7:0] req_slice_ticks = '0;
   logic rsp_valid;
   logic [1:0] rsp_status;
   logic [5:0] rsp_result_task;
   logic [7:0] rsp_reload_ticks;
   logic rsp_do_jump;
   logic [3:0] rsp_active_level;

   multilevel_round_robin_scheduler_unit dut (.*);

   always #10 clock = ~clock;

   // scheduler model state
   mrrs_pkg::slot_state_type m_state [SLOTS];
   logic [2:0]     m_level [SLOTS];
   logic [7:0]     m_slice [SLOTS];
   logic [5:0]     m_list  [NLEV][DEPTH];
   int             m_count [NLEV];
   int             m_pos   [NLEV];
   int             m_serve;
   bit             m_pending;

   cmd_t  pending_cmds[$];
   resp_t expected_resps[$];
   int    mismatches = 0;
   int    cycles = 0;
   int    send_idle_pct = 0;
   bit    hold_send = 0;

   function automatic void sched_reset();
      for (int i = 0; i < SLOTS; i++) begin
         m_state[i] = mrrs_pkg::SLOT_FREE; m_level[i] = 0; m_slice[i] = 0;
      end
      for (int l = 0; l < NLEV; l++) begin
         m_count[l] = 0; m_pos[l] = 0;
         for (int j = 0; j < DEPTH; j++) m_list[l][j] = 0;
      end
      m_state[0] = mrrs_pkg::SLOT_ACTIVE; m_slice[0] = 2;
      m_state[1] = mrrs_pkg::SLOT_ACTIVE; m_level[1] = 3'(NLEV - 1); m_slice[1] = 1;
      m_list[0][0] = 0; m_count[0] = 1;
      m_list[NLEV-1][0] = 1; m_count[NLEV-1] = 1;
      m_serve = 0; m_pending = 0;
   endfunction

   function automatic int running_task();
      if (m_serve >= NLEV || m_count[m_serve] == 0 || m_pos[m_serve] >= DEPTH) return -1;
      return m_list[m_serve][m_pos[m_serve]];
   endfunction

   function automatic void find_level();
      int i;
      for (i = 0; i < NLEV; i++) if (m_count[i] > 0) break;
      m_serve = i;
      m_pending = 0;
   endfunction

   function automatic bit enlist(int t);
      int l;
      l = m_level[t];
      if (m_count[l] >= DEPTH) return 0;
      m_list[l][m_count[l]] = 6'(t);
      m_count[l]++;
      m_state[t] = mrrs_pkg::SLOT_ACTIVE;
      return 1;
   endfunction

   function automatic void delist(int t);
      int l, i, n;
      l = m_level[t];
      m_state[t] = mrrs_pkg::SLOT_ALLOC;
      n = m_count[l];
      for (i = 0; i < n; i++) if (m_list[l][i] == t) break;
      if (i >= n) return;
      n--;
      m_count[l] = n;
      if (i < m_pos[l]) m_pos[l]--;
      if (m_pos[l] >= n) m_pos[l] = 0;
      for (; i < n; i++) m_list[l][i] = m_list[l][i+1];
   endfunction

   function automatic resp_t sched_step(cmd_t c);
      resp_t r;
      int prev_task, cur, l, i;
      r = '0;
      r.status = mrrs_pkg::STAT_OK;
      if (c.op == mrrs_pkg::OP_ALLOC) begin
         for (i = 0; i < SLOTS; i++) if (m_state[i] == mrrs_pkg::SLOT_FREE) break;
         if (i < SLOTS) begin
            m_state[i] = mrrs_pkg::SLOT_ALLOC; r.task_id = 6'(i);
         end else r.status = mrrs_pkg::STAT_NOSLOT;
      end else if (c.op == mrrs_pkg::OP_TICK) begin
         prev_task = running_task();
         l = m_serve;
         if (l < NLEV) begin
            if (m_count[l] == 0) m_pos[l] = 0;
            else begin
               m_pos[l]++;
               if (m_pos[l] >= m_count[l]) m_pos[l] = 0;
            end
         end
         if (m_pending || l >= NLEV || m_count[l] == 0) find_level();
         cur = running_task();
         if (cur < 0) r.status = mrrs_pkg::STAT_NORUN;
         else begin
            r.reload = m_slice[cur];
            r.jump = (prev_task != cur);
         end
      end else if (c.op == mrrs_pkg::OP_RUN) begin
         if (c.lvl < 0) l = m_level[c.tid];
         else l = (c.lvl >= NLEV) ? NLEV - 1 : c.lvl;
         if (c.slice != 0) m_slice[c.tid] = c.slice;
         if (m_state[c.tid] == mrrs_pkg::SLOT_ACTIVE && m_level[c.tid] != l) delist(c.tid);
         if (m_state[c.tid] != mrrs_pkg::SLOT_ACTIVE) begin
            m_level[c.tid] = 3'(l);
            if (!enlist(c.tid)) r.status = mrrs_pkg::STAT_FULL;
         end
         m_pending = 1;
      end else if (m_state[c.tid] == mrrs_pkg::SLOT_ACTIVE) begin
         prev_task = running_task();
         delist(c.tid);
         if (prev_task == c.tid) begin
            find_level();
            if (running_task() < 0) r.status = mrrs_pkg::STAT_NORUN;
            else r.jump = 1;
         end
      end
      if (c.op != mrrs_pkg::OP_ALLOC) begin
         cur = running_task();
         r.task_id = (cur < 0) ? 6'd0 : 6'(cur);
      end
      r.level = 4'(m_serve);
      return r;
   endfunction

   function automatic cmd_t make_cmd(mrrs_pkg::op_type op, int tid, int lvl, int slice);
      cmd_t c;
      c.op = op; c.tid = 6'(tid); c.lvl = 4'(lvl); c.slice = 8'(slice);
      return c;
   endfunction

   function automatic cmd_t rand_cmd();
      int pick;
      cmd_t c;
      pick = $urandom_range(0, 99);
      c.tid = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                          : 6'($urandom_range(0, 23));
      c.lvl = 4'($urandom_range(0, 15));
      c.slice = 8'($urandom_range(0, 255));
      if (pick < 30) c.op = mrrs_pkg::OP_TICK;
      else if (pick < 62) c.op = mrrs_pkg::OP_RUN;
      else if (pick < 85) c.op = mrrs_pkg::OP_SLEEP;
      else c.op = mrrs_pkg::OP_ALLOC;
      return c;
   endfunction

   // driver: present one beat at a time; when one is taken, present the next or drop start
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (start && !busy) begin
            if (pending_cmds.size() > 0 && !hold_send
                && $urandom_range(0, 99) >= send_idle_pct) begin
               cmd_t c;
               c = pending_cmds.pop_front();
               expected_resps.push_back(sched_step(c));
               req_operation <= c.op; req_task_id <= c.tid;
               req_target_level <= c.lvl; req_slice_ticks <= c.slice;
            end else start <= 0;
         end else if (!start && pending_cmds.size() > 0 && !hold_send
                      && $urandom_range(0, 99) >= send_idle_pct) begin
            cmd_t c;
            c = pending_cmds.pop_front();
            expected_resps.push_back(sched_step(c));
            req_operation <= c.op; req_task_id <= c.tid;
            req_target_level <= c.lvl; req_slice_ticks <= c.slice;
            start <= 1;
         end
      end
   end

   // monitor: compare every response beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         resp_t got, want;
         got = {rsp_status, rsp_result_task, rsp_reload_ticks, rsp_do_jump, rsp_active_level};
         if (expected_resps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat %h", got);
         end else begin
            want = expected_resps.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp st=%0d task=%0d rl=%0d j=%0d lv=%0d",
                            " got st=%0d task=%0d rl=%0d j=%0d lv=%0d"},
                     want.status, want.task_id, want.reload, want.jump, want.level,
                     got.status, got.task_id, got.reload, got.jump, got.level);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic drain();
      while (pending_cmds.size() > 0 || start || expected_resps.size() > 0) @(posedge clock);
   endtask

   initial begin
      sched_reset();
      repeat (9) @(posedge clock);
      reset <= 0;

      // directed: boot state, extremes, every operation and corner
      pending_cmds.push_back(make_cmd(mrrs_pkg::OP_TICK, 0, 0, 0));
      pending_cmds.push_back(make_cmd(mrrs_pkg::OP_TICK, 0, 0, 0));
      pending_cmds.push_back(make_cmd(mrrs_pkg::OP_ALLOC, 0, 0, 0));
      pending_cmds.push_back(make_cmd(mrrs_pkg::OP_RUN, 2, 15, 255));
      pending_cmds.push_back(make_cmd(mrrs_pkg::OP_RUN, 2, -1, 0));
      pending_cmds.push_back(make_cmd(mrrs_pkg::OP_RUN, 2, 3, 7));
      pending_cmds.push_back(make_cmd(mrrs_pkg::OP_RUN, 63, 7, 0));
      pending_cmds.push_back(make_cmd(mrrs_pkg::OP_SLEEP, 40, 0, 0));
      pending_cmds.push_back(make_cmd(mrrs_pkg::OP_SLEEP, 0, 0, 0));
      pending_cmds.push_back(make_cmd(mrrs_pkg::OP_TICK, 0, 0, 0));
      pending_cmds.push_back(make_cmd(mrrs_pkg::OP_SLEEP, 2, 0, 0));
      pending_cmds.push_back(make_cmd(mrrs_pkg::OP_SLEEP, 63, 0, 0));
      pending_cmds.push_back(make_cmd(mrrs_pkg::OP_SLEEP, 1, 0, 0));
      pending_cmds.push_back(make_cmd(mrrs_pkg::OP_TICK, 0, 0, 0));
      pending_cmds.push_back(make_cmd(mrrs_pkg::OP_TICK, 0, 0, 0));
      for (int i = 0; i < 18; i++)
         pending_cmds.push_back(make_cmd(mrrs_pkg::OP_RUN, i + 3, 5, i));
      pending_cmds.push_back(make_cmd(mrrs_pkg::OP_TICK, 0, 0, 0));
      drain();

      // pause until every beat is back, then random phases
      hold_send = 1;
      repeat (5) @(posedge clock);
      hold_send = 0;
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1) ? 76 : (ph == 3) ? 31 : 0;
         for (int i = 0; i < 500; i++) begin
            // third phase fills every slot first so allocation runs out
            if (ph == 2 && i < 70)
               pending_cmds.push_back(make_cmd(mrrs_pkg::OP_ALLOC, 0, 0, 0));
            else pending_cmds.push_back(rand_cmd());
         end
         drain();
      end
      repeat (200) @(posedge clock);
      if (mismatches == 0 && expected_resps.size() == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule
